// ===== design/distance_vector_route_table_defines.svh =====
// Assertion helpers used by the checks in the route table.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define DVRT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A trigger that forces a condition at the following clock edge.
`define DVRT_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/dvrt_pkg.sv =====
package dvrt_pkg;

  // Default geometry of the table.
  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned PathHopsDefault   = 8;

  // Configuration port.
  localparam int unsigned AddrWidth   = 3;
  localparam logic [15:0] InfResetVal = 16'd999;

  typedef enum logic [0:0] {
    REG_MY_ID    = 1'b0,
    REG_INFINITY = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_ADD   = 3'd1,
    OP_ROUTE = 3'd2,
    OP_DEAD  = 3'd3,
    OP_DUMP  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_STATUS = 3'b100
  } state_e;

  // One stored route.
  typedef struct packed {
    logic [3:0]  dest;
    logic [3:0]  hop;
    logic [15:0] cost;
    logic [3:0]  plen;
    logic [31:0] path;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic [3:0]  out_dest;
    logic [3:0]  out_next_hop;
    logic [15:0] out_cost;
    logic [3:0]  out_path_len;
    logic [31:0] out_path;
    logic        changed;
    logic        table_full;
    logic        last;
  } result_t;

endpackage

// ===== design/dvrt_in_if.sv =====
interface dvrt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  nbr_id;
  logic [15:0] link_cost;
  logic [3:0]  dest_id;
  logic [15:0] route_cost;
  logic [2:0]  route_path_len;
  logic [27:0] route_path;

  modport source (
    output valid, opcode, nbr_id, link_cost, dest_id, route_cost, route_path_len,
    route_path,
    input  ready
  );
  modport sink (
    input  valid, opcode, nbr_id, link_cost, dest_id, route_cost, route_path_len,
    route_path,
    output ready
  );
endinterface

// ===== design/dvrt_out_if.sv =====
interface dvrt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_dest;
  logic [3:0]  out_next_hop;
  logic [15:0] out_cost;
  logic [3:0]  out_path_len;
  logic [31:0] out_path;
  logic        changed;
  logic        table_full;
  logic        last;

  modport source (
    output valid, out_dest, out_next_hop, out_cost, out_path_len, out_path, changed,
    table_full, last,
    input  ready
  );
  modport sink (
    input  valid, out_dest, out_next_hop, out_cost, out_path_len, out_path, changed,
    table_full, last,
    output ready
  );
endinterface

// ===== design/dvrt_cell.sv =====
module dvrt_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  dvrt_pkg::entry_t d_i,
  output dvrt_pkg::entry_t q_o
);

  dvrt_pkg::entry_t entry_q;

  // Take the neighbor's entry whenever the ring advances.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ===== design/distance_vector_route_table.sv =====
// Distance-vector route table. The routes live in a ring of TABLE_DEPTH cells
// that rotates by one place per cycle while a command runs, unless a dump is
// held by the output side; the entry at the head is examined and rewritten by
// a single update unit and then passed on to the tail. Every command makes one
// full turn of the ring; all but a dump then go through the status state,
// which issues the status word and frees the input. A dump delivers one entry
// per cycle while the output side keeps up and frees the input right after its
// turn. A new word is taken only when the previous one is finished.
// The table needs no clearing pass after reset; only entries below the entry
// count are ever read. Registers: my_id at byte address 0, infinity_cost at 4.
`include "distance_vector_route_table_defines.svh"

module distance_vector_route_table #(
  parameter int unsigned TABLE_DEPTH = dvrt_pkg::TableDepthDefault,
  parameter int unsigned PATH_HOPS   = dvrt_pkg::PathHopsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dvrt_in_if.sink                        in_i,
  dvrt_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dvrt_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = $clog2(TABLE_DEPTH);
  localparam logic [SW-1:0] LastStep = SW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(TABLE_DEPTH);
  localparam logic [2:0]    HopMax   = 3'(PATH_HOPS - 1);

  // Configuration registers.
  logic [3:0]  my_id_q;
  logic [15:0] inf_q;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dvrt_pkg::REG_INFINITY) ? {16'b0, inf_q} : {28'b0, my_id_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_id_q <= '0;
      inf_q   <= dvrt_pkg::InfResetVal;
    end else if (cfg_wr) begin
      if (paddr[2] == dvrt_pkg::REG_INFINITY) begin
        inf_q <= pwdata[15:0];
      end else begin
        my_id_q <= pwdata[3:0];
      end
    end
  end

  // Control state.
  dvrt_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [SW-1:0]     step_q, step_d;
  logic              found_q, found_d;
  logic              chg_q, chg_d;
  logic              out_valid_q, out_valid_d;
  dvrt_pkg::result_t out_q, out_d;

  // Latched command.
  dvrt_pkg::opcode_e op_q;
  logic [3:0]        sender_q, dest_q;
  logic [15:0]       sum_q, rclamp_q;
  logic [2:0]        alen_q;
  logic [27:0]       apath_q;
  logic              has_self_q;

  logic              accept;
  assign in_i.ready = (state_q == dvrt_pkg::S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Prepare the advertised route at acceptance.
  logic [16:0] raw_sum;
  logic [2:0]  alen_sat;
  logic [27:0] apath_mask;
  logic        self_hit;

  always_comb begin
    raw_sum    = {1'b0, in_i.link_cost} + {1'b0, in_i.route_cost};
    alen_sat   = (in_i.route_path_len > HopMax) ? HopMax : in_i.route_path_len;
    apath_mask = '0;
    self_hit   = 1'b0;
    for (int x = 0; x < 7; x++) begin
      if (3'(x) < alen_sat) begin
        apath_mask[4*x +: 4] = in_i.route_path[4*x +: 4];
        if (in_i.route_path[4*x +: 4] == my_id_q) begin
          self_hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= dvrt_pkg::opcode_e'(in_i.opcode);
      sender_q   <= in_i.nbr_id;
      dest_q     <= in_i.dest_id;
      sum_q      <= (raw_sum > {1'b0, inf_q}) ? inf_q : raw_sum[15:0];
      rclamp_q   <= (in_i.route_cost > inf_q) ? inf_q : in_i.route_cost;
      alen_q     <= alen_sat;
      apath_q    <= apath_mask;
      has_self_q <= self_hit;
    end
  end

  // Ring of cells.
  dvrt_pkg::entry_t cell_q [TABLE_DEPTH];
  dvrt_pkg::entry_t new_head;
  logic             shift;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      dvrt_cell u_cell (.clk_i(clk_i), .shift_i(shift), .d_i(new_head), .q_o(cell_q[i]));
    end else begin : g_body
      dvrt_cell u_cell (.clk_i(clk_i), .shift_i(shift), .d_i(cell_q[i+1]), .q_o(cell_q[i]));
    end
  end

  // Update unit at the head of the ring.
  dvrt_pkg::entry_t head;
  logic [CW-1:0]    k_ext;
  logic             in_range, append_slot, mismatch, dump_emit, stall;
  logic [31:0]      npath;

  always_comb begin
    head        = cell_q[0];
    new_head    = head;
    k_ext       = CW'(step_q);
    in_range    = k_ext < count_q;
    append_slot = (k_ext == count_q) && !found_q;
    npath       = {apath_q, my_id_q};
    mismatch    = 1'b0;
    for (int x = 0; x < 7; x++) begin
      if (3'(x) < alen_q && head.path[4*(x+1) +: 4] != apath_q[4*x +: 4]) begin
        mismatch = 1'b1;
      end
    end

    count_d     = count_q;
    found_d     = found_q;
    chg_d       = chg_q;
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    shift       = 1'b0;

    dump_emit = (op_q == dvrt_pkg::OP_DUMP) &&
                (in_range || (count_q == '0 && step_q == '0));
    stall     = dump_emit && out_valid_q && !out_o.ready;

    case (state_q)
      dvrt_pkg::S_IDLE: begin
        if (accept) begin
          state_d = dvrt_pkg::S_SCAN;
          step_d  = '0;
          found_d = 1'b0;
          chg_d   = 1'b0;
        end
      end
      dvrt_pkg::S_SCAN: begin
        if (!stall) begin
          shift  = 1'b1;
          step_d = step_q + 1'b1;
          case (op_q)
            dvrt_pkg::OP_INIT: begin
              if (step_q == '0) begin
                new_head = '{dest: my_id_q, hop: my_id_q, cost: '0, plen: 4'd1,
                             path: {28'b0, my_id_q}};
                count_d  = CW'(1);
                chg_d    = 1'b1;
              end
            end
            dvrt_pkg::OP_ADD: begin
              if (append_slot) begin
                new_head = '{dest: dest_q, hop: dest_q, cost: rclamp_q, plen: 4'd2,
                             path: {24'b0, dest_q, my_id_q}};
                count_d  = count_q + 1'b1;
                found_d  = 1'b1;
                chg_d    = 1'b1;
              end
            end
            dvrt_pkg::OP_ROUTE: begin
              if (in_range && !found_q && head.dest == dest_q) begin
                found_d = 1'b1;
                if (sender_q == head.hop) begin
                  if (mismatch) begin
                    chg_d = 1'b1;
                  end
                  if (sum_q != head.cost) begin
                    new_head.cost = sum_q;
                    new_head.plen = {1'b0, alen_q} + 4'd1;
                    new_head.path = npath;
                    chg_d         = 1'b1;
                  end
                end
                if (!has_self_q && new_head.cost > sum_q) begin
                  new_head.cost = sum_q;
                  new_head.plen = {1'b0, alen_q} + 4'd1;
                  new_head.path = npath;
                  new_head.hop  = sender_q;
                  chg_d         = 1'b1;
                end
              end else if (append_slot) begin
                new_head = '{dest: dest_q, hop: sender_q, cost: sum_q,
                             plen: {1'b0, alen_q} + 4'd1, path: npath};
                count_d  = count_q + 1'b1;
                found_d  = 1'b1;
                chg_d    = 1'b1;
              end
            end
            dvrt_pkg::OP_DEAD: begin
              if (in_range && head.hop == sender_q) begin
                if (head.cost != inf_q) begin
                  chg_d = 1'b1;
                end
                new_head.cost = inf_q;
              end
            end
            default: begin
            end
          endcase
          // Dump words leave straight from the head.
          if (dump_emit) begin
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.last  = 1'b1;
            if (in_range) begin
              out_d.out_dest     = head.dest;
              out_d.out_next_hop = head.hop;
              out_d.out_cost     = head.cost;
              out_d.out_path_len = head.plen;
              out_d.out_path     = head.path;
              out_d.last         = (k_ext + 1'b1) == count_q;
            end
          end
          if (step_q == LastStep) begin
            state_d = (op_q == dvrt_pkg::OP_DUMP) ? dvrt_pkg::S_IDLE : dvrt_pkg::S_STATUS;
          end
        end
      end
      dvrt_pkg::S_STATUS: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d      = 1'b1;
          out_d            = '0;
          out_d.changed    = chg_q;
          out_d.table_full = ((op_q == dvrt_pkg::OP_ADD) || (op_q == dvrt_pkg::OP_ROUTE)) &&
                             !found_q;
          out_d.last       = 1'b1;
          state_d          = dvrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dvrt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dvrt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    found_q <= found_d;
    chg_q   <= chg_d;
    out_q   <= out_d;
  end

  // Output word.
  assign out_o.valid        = out_valid_q;
  assign out_o.out_dest     = out_q.out_dest;
  assign out_o.out_next_hop = out_q.out_next_hop;
  assign out_o.out_cost     = out_q.out_cost;
  assign out_o.out_path_len = out_q.out_path_len;
  assign out_o.out_path     = out_q.out_path;
  assign out_o.changed      = out_q.changed;
  assign out_o.table_full   = out_q.table_full;
  assign out_o.last         = out_q.last;

  // Checks.
  `DVRT_ASSERT_ALWAYS(a_count_bound, count_q <= DepthCnt, "entry count beyond table depth")
  `DVRT_ASSERT_ALWAYS(a_more_words, !(out_valid_q && !out_q.last) || state_q == dvrt_pkg::S_SCAN, "non-final word without a dump in progress")
  `DVRT_ASSERT_NEXT(a_scan_start, accept, state_q == dvrt_pkg::S_SCAN && step_q == '0, "accepted word did not start a scan")

endmodule

// ===== tb/dvrt_tb_pkg.sv =====
`timescale 1ns / 100ps
package dvrt_tb_pkg;

  // One command word as offered to the block.
  typedef struct {
    logic [2:0]  opcode;
    logic [3:0]  nbr_id;
    logic [15:0] link_cost;
    logic [3:0]  dest_id;
    logic [15:0] route_cost;
    logic [2:0]  route_path_len;
    logic [27:0] route_path;
  } cmd_t;

  // Route table model and the queue of result words it predicts.
  class route_scoreboard;
    dvrt_pkg::entry_t  routes[dvrt_pkg::TableDepthDefault];
    int unsigned       n_routes;
    logic [3:0]        self_id;
    logic [15:0]       inf_cost;
    dvrt_pkg::result_t pending[$];
    int unsigned       n_errors;
    int unsigned       n_checked;

    function new();
      n_routes = 0;
      self_id = '0;
      inf_cost = 16'd999;
      n_errors = 0;
      n_checked = 0;
    endfunction

    function logic [15:0] clamp(logic [16:0] c);
      return (c > {1'b0, inf_cost}) ? inf_cost : c[15:0];
    endfunction

    function void push_status(logic chg, logic full);
      dvrt_pkg::result_t r;
      r = '0;
      r.changed = chg;
      r.table_full = full;
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    // Update the model with one accepted command and queue its results.
    function void note_command(cmd_t c);
      logic              chg;
      logic              full;
      logic [2:0]        alen;
      logic [27:0]       apath;
      logic [31:0]       npath;
      logic [15:0]       sum;
      logic              hit;
      logic              has_self;
      int                m;
      dvrt_pkg::result_t r;
      chg = 1'b0;
      full = 1'b0;
      hit = 1'b0;
      has_self = 1'b0;
      m = 0;
      case (c.opcode)
        dvrt_pkg::OP_INIT: begin
          routes[0] = '{dest: self_id, hop: self_id, cost: '0, plen: 4'd1,
                        path: {28'd0, self_id}};
          n_routes = 1;
          chg = 1'b1;
        end
        dvrt_pkg::OP_ADD: begin
          if (n_routes >= dvrt_pkg::TableDepthDefault) begin
            full = 1'b1;
          end else begin
            routes[n_routes] = '{dest: c.dest_id, hop: c.dest_id,
                                 cost: clamp({1'b0, c.route_cost}), plen: 4'd2,
                                 path: {24'd0, c.dest_id, self_id}};
            n_routes++;
            chg = 1'b1;
          end
        end
        dvrt_pkg::OP_ROUTE: begin
          sum = clamp({1'b0, c.link_cost} + {1'b0, c.route_cost});
          alen = (c.route_path_len > 3'd7) ? 3'd7 : c.route_path_len;
          apath = '0;
          for (int x = 0; x < alen; x++) apath[4*x +: 4] = c.route_path[4*x +: 4];
          npath = {apath, self_id};
          for (int i = 0; i < n_routes; i++) begin
            if (!hit && routes[i].dest == c.dest_id) begin
              hit = 1'b1;
              m = i;
            end
          end
          if (hit) begin
            if (c.nbr_id == routes[m].hop) begin
              for (int x = 0; x < alen; x++)
                if (routes[m].path[4*(x+1) +: 4] != apath[4*x +: 4]) chg = 1'b1;
              if (sum != routes[m].cost) begin
                routes[m].cost = sum;
                routes[m].plen = {1'b0, alen} + 4'd1;
                routes[m].path = npath;
                chg = 1'b1;
              end
            end
            for (int x = 0; x < alen; x++)
              if (apath[4*x +: 4] == self_id) has_self = 1'b1;
            if (!has_self && routes[m].cost > sum) begin
              routes[m].cost = sum;
              routes[m].plen = {1'b0, alen} + 4'd1;
              routes[m].path = npath;
              routes[m].hop = c.nbr_id;
              chg = 1'b1;
            end
          end else if (n_routes >= dvrt_pkg::TableDepthDefault) begin
            full = 1'b1;
          end else begin
            routes[n_routes] = '{dest: c.dest_id, hop: c.nbr_id, cost: sum,
                                 plen: {1'b0, alen} + 4'd1, path: npath};
            n_routes++;
            chg = 1'b1;
          end
        end
        dvrt_pkg::OP_DEAD: begin
          for (int i = 0; i < n_routes; i++) begin
            if (routes[i].hop == c.nbr_id) begin
              if (routes[i].cost != inf_cost) chg = 1'b1;
              routes[i].cost = inf_cost;
            end
          end
        end
        dvrt_pkg::OP_DUMP: begin
          if (n_routes == 0) begin
            push_status(1'b0, 1'b0);
          end else begin
            for (int i = 0; i < n_routes; i++) begin
              r = '0;
              r.out_dest = routes[i].dest;
              r.out_next_hop = routes[i].hop;
              r.out_cost = routes[i].cost;
              r.out_path_len = routes[i].plen;
              r.out_path = routes[i].path;
              r.last = (i + 1 == n_routes);
              pending.push_back(r);
            end
          end
          return;
        end
        default: ;
      endcase
      push_status(chg, full);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
      n_errors++;
    endfunction

    // Compare one delivered word with the oldest prediction.
    function void check_word(dvrt_pkg::result_t got);
      dvrt_pkg::result_t exp_w;
      if (pending.size() == 0) begin
        report("unexpected word", got.out_path, '0);
        return;
      end
      exp_w = pending.pop_front();
      n_checked++;
      if (got.out_dest !== exp_w.out_dest)
        report("out_dest", 32'(got.out_dest), 32'(exp_w.out_dest));
      if (got.out_next_hop !== exp_w.out_next_hop)
        report("out_next_hop", 32'(got.out_next_hop), 32'(exp_w.out_next_hop));
      if (got.out_cost !== exp_w.out_cost)
        report("out_cost", 32'(got.out_cost), 32'(exp_w.out_cost));
      if (got.out_path_len !== exp_w.out_path_len)
        report("out_path_len", 32'(got.out_path_len), 32'(exp_w.out_path_len));
      if (got.out_path !== exp_w.out_path) report("out_path", got.out_path, exp_w.out_path);
      if (got.changed !== exp_w.changed)
        report("changed", 32'(got.changed), 32'(exp_w.changed));
      if (got.table_full !== exp_w.table_full)
        report("table_full", 32'(got.table_full), 32'(exp_w.table_full));
      if (got.last !== exp_w.last) report("last", 32'(got.last), 32'(exp_w.last));
    endfunction
  endclass
endpackage

// ===== tb/dvrt_tb_ifs.sv =====
`timescale 1ns / 100ps
// The channel interfaces come from the design folder; nothing extra is needed
// here beyond a probe bundle used by the testbench to drive the APB port.
interface dvrt_apb_if;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
endinterface

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned CycleLimit = 2000000;

  logic clk_i;
  logic rst_ni;
  dvrt_in_if  in_ch ();
  dvrt_out_if out_ch ();
  dvrt_apb_if apb ();

  dvrt_tb_pkg::route_scoreboard sb;
  int unsigned cycles;
  int unsigned n_sent;
  int unsigned n_words;
  bit          hold_off;
  bit          stim_done;

  distance_vector_route_table u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (apb.psel),
    .penable (apb.penable),
    .pwrite  (apb.pwrite),
    .paddr   (apb.paddr),
    .pwdata  (apb.pwdata),
    .prdata  (apb.prdata),
    .pready  (apb.pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** distance_vector_route_table: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      dvrt_pkg::result_t w;
      w.out_dest = out_ch.out_dest;
      w.out_next_hop = out_ch.out_next_hop;
      w.out_cost = out_ch.out_cost;
      w.out_path_len = out_ch.out_path_len;
      w.out_path = out_ch.out_path;
      w.changed = out_ch.changed;
      w.table_full = out_ch.table_full;
      w.last = out_ch.last;
      sb.check_word(w);
      n_words++;
    end
  end

  initial begin : result_ready
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Register write through the APB port: setup, then access, then back to idle.
  task automatic reg_write(dvrt_pkg::reg_idx_e idx, logic [31:0] value);
    apb.psel <= 1'b1;
    apb.penable <= 1'b0;
    apb.pwrite <= 1'b1;
    apb.paddr <= {idx, 2'b00};
    apb.pwdata <= value;
    @(posedge clk_i);
    apb.penable <= 1'b1;
    @(posedge clk_i);
    while (!apb.pready) @(posedge clk_i);
    apb.psel <= 1'b0;
    apb.penable <= 1'b0;
    apb.pwrite <= 1'b0;
    if (idx == dvrt_pkg::REG_MY_ID) sb.self_id = value[3:0];
    else sb.inf_cost = value[15:0];
    @(posedge clk_i);
  endtask

  // Offer one command word and hold it until it is taken. Valid stays high
  // afterwards unless a gap follows, so back-to-back offers need no toggle.
  task automatic send_cmd(dvrt_tb_pkg::cmd_t c, bit idle);
    int gap;
    gap = 0;
    if (idle) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= c.opcode;
    in_ch.nbr_id <= c.nbr_id;
    in_ch.link_cost <= c.link_cost;
    in_ch.dest_id <= c.dest_id;
    in_ch.route_cost <= c.route_cost;
    in_ch.route_path_len <= c.route_path_len;
    in_ch.route_path <= c.route_path;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_command(c);
    n_sent++;
  endtask

  function automatic dvrt_tb_pkg::cmd_t mk(logic [2:0] op, logic [3:0] snd, logic [15:0] lc,
                                           logic [3:0] dst, logic [15:0] rc, logic [2:0] len,
                                           logic [27:0] p);
    dvrt_tb_pkg::cmd_t c;
    c.opcode = op;
    c.nbr_id = snd;
    c.link_cost = lc;
    c.dest_id = dst;
    c.route_cost = rc;
    c.route_path_len = len;
    c.route_path = p;
    return c;
  endfunction

  // Random command weighted toward well-formed updates on a small id set.
  function automatic dvrt_tb_pkg::cmd_t rand_cmd();
    dvrt_tb_pkg::cmd_t c;
    int                sel;
    c = mk(dvrt_pkg::OP_ROUTE, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 200)),
           4'($urandom_range(0, 15)), 16'($urandom_range(0, 600)),
           3'($urandom_range(0, 7)), 28'($urandom()));
    if ($urandom_range(0, 7) == 0) begin
      c.link_cost = 16'($urandom());
      c.route_cost = 16'($urandom());
    end
    if ($urandom_range(0, 2) != 0) begin
      c.nbr_id = 4'($urandom_range(1, 4));
      c.dest_id = 4'($urandom_range(0, 7));
    end
    sel = $urandom_range(0, 99);
    if (sel < 4) c.opcode = dvrt_pkg::OP_INIT;
    else if (sel < 16) c.opcode = dvrt_pkg::OP_ADD;
    else if (sel < 70) c.opcode = dvrt_pkg::OP_ROUTE;
    else if (sel < 80) c.opcode = dvrt_pkg::OP_DEAD;
    else if (sel < 96) c.opcode = dvrt_pkg::OP_DUMP;
    else c.opcode = 3'($urandom_range(5, 7));
    return c;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin : stimulus
    cycles = 0;
    n_sent = 0;
    n_words = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    sb = new();
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.nbr_id = '0;
    in_ch.link_cost = '0;
    in_ch.dest_id = '0;
    in_ch.route_cost = '0;
    in_ch.route_path_len = '0;
    in_ch.route_path = '0;
    apb.psel = 1'b0;
    apb.penable = 1'b0;
    apb.pwrite = 1'b0;
    apb.paddr = '0;
    apb.pwdata = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty dump, unused opcode, then every command and the extremes.
    send_cmd(mk(dvrt_pkg::OP_DUMP, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cmd(mk(3'd7, 4'hf, 16'hffff, 4'hf, 16'hffff, 3'd7, 28'hfffffff), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_INIT, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_ADD, '0, '0, 4'd1, 16'd5, '0, '0), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_ADD, '0, '0, 4'd2, 16'hffff, '0, '0), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_ROUTE, 4'd1, 16'hffff, 4'd9, 16'hffff, 3'd7, 28'hfffffff), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_ROUTE, 4'd1, 16'd3, 4'd2, 16'd4, 3'd2, 28'h0000021), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_ROUTE, 4'd1, 16'd3, 4'd2, 16'd4, 3'd2, 28'h0000031), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_ROUTE, 4'd2, 16'd0, 4'd9, 16'd0, 3'd1, 28'h0000000), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_ROUTE, 4'd1, 16'd1, 4'd9, 16'd1, 3'd7, 28'h1234567), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_DEAD, 4'd1, '0, '0, '0, '0, '0), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_DEAD, 4'd1, '0, '0, '0, '0, '0), 1'b0);
    for (int i = 0; i < 14; i++)
      send_cmd(mk(dvrt_pkg::OP_ADD, '0, '0, i[3:0], i[15:0], '0, '0), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_ROUTE, 4'd3, 16'd1, 4'd15, 16'd1, 3'd1, 28'h3), 1'b0);
    send_cmd(mk(dvrt_pkg::OP_DUMP, '0, '0, '0, '0, '0, '0), 1'b0);
    drain();

    // Random phases under several register settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          reg_write(dvrt_pkg::REG_MY_ID, 32'd15);
          reg_write(dvrt_pkg::REG_INFINITY, 32'd1);
        end
        1: begin
          reg_write(dvrt_pkg::REG_MY_ID, 32'd2);
          reg_write(dvrt_pkg::REG_INFINITY, 32'd65535);
        end
        2: begin
          reg_write(dvrt_pkg::REG_MY_ID, 32'd0);
          reg_write(dvrt_pkg::REG_INFINITY, 32'd999);
        end
        default: begin
          reg_write(dvrt_pkg::REG_MY_ID, $urandom_range(0, 15));
          reg_write(dvrt_pkg::REG_INFINITY, $urandom_range(1, 300));
        end
      endcase
      send_cmd(mk(dvrt_pkg::OP_INIT, '0, '0, '0, '0, '0, '0), 1'b1);
      if (ph == 1) hold_off = 1'b1;
      for (int k = 0; k < 95; k++) send_cmd(rand_cmd(), (k % 30) > 10);
      send_cmd(mk(dvrt_pkg::OP_DUMP, '0, '0, '0, '0, '0, '0), 1'b1);
      drain();
    end
    stim_done = 1'b1;

    $display("Sent %0d commands, checked %0d result words across four register settings.",
             n_sent, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("** distance_vector_route_table: PASSED **");
    end else begin
      $display("%0d mismatches, %0d words still expected.", sb.n_errors, sb.pending.size());
      $display("** distance_vector_route_table: FAILED **");
    end
    $finish;
  end

endmodule
